@@ hdl/ldc_link_handshake_reassembly_defines.svh @@
// ----------------------------------------------------------------------------
// ldc link handshake reassembly assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef LDC_LINK_HANDSHAKE_REASSEMBLY_DEFINES_SVH
`define LDC_LINK_HANDSHAKE_REASSEMBLY_DEFINES_SVH

// same-cycle implication
`define LDC_LHR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ldc_lhr: same-cycle check failed");

// next-cycle implication
`define LDC_LHR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ldc_lhr: next-cycle check failed");

`endif

@@ hdl/ldc_lhr_pkg.sv @@
// ----------------------------------------------------------------------------
// ldc link handshake reassembly package
// shared types, codes and sizes of the link receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ldc_lhr_pkg;

	// message buffer size and derived widths
	localparam int unsigned MSG_BYTES = 4096;
	localparam int unsigned ASM_W     = $clog2(MSG_BYTES + 1);
	localparam int unsigned SUM_W     = ASM_W + 1;
	localparam int unsigned OFF_W     = $clog2(MSG_BYTES);
	localparam int unsigned FRAG_W    = 6;

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_SND_VERS = 3'd1,
		ST_RCV_VERS = 3'd2,
		ST_SND_RTS  = 3'd3,
		ST_SND_RTR  = 3'd4,
		ST_SND_RDX  = 3'd5
	} hs_state_t;

	// packet kinds to transmit
	localparam logic [2:0] SK_NONE      = 3'd0;
	localparam logic [2:0] SK_VERS_INFO = 3'd1;
	localparam logic [2:0] SK_VERS_ACK  = 3'd2;
	localparam logic [2:0] SK_RTS       = 3'd3;
	localparam logic [2:0] SK_RTR       = 3'd4;
	localparam logic [2:0] SK_RDX       = 3'd5;
	localparam logic [2:0] SK_DATA_ACK  = 3'd6;

	// received subtypes
	localparam logic [1:0] SUB_INFO = 2'd0;
	localparam logic [1:0] SUB_ACK  = 2'd1;

	// control codes
	localparam logic [2:0] CC_VERSION = 3'd0;
	localparam logic [2:0] CC_RTS     = 3'd1;
	localparam logic [2:0] CC_RTR     = 3'd2;
	localparam logic [2:0] CC_RDX     = 3'd3;

	// envelope layout
	localparam int unsigned ENV_START_BIT = 6;
	localparam int unsigned ENV_STOP_BIT  = 7;
	localparam logic [7:0]  MODE_RELIABLE = 8'h03;

	// configuration register indexes
	localparam logic CFG_MAJOR = 1'b0;
	localparam logic CFG_MINOR = 1'b1;

	typedef struct packed {
		logic        operation;
		logic        packet_kind;
		logic [1:0]  subtype;
		logic [2:0]  ctrl_code;
		logic [7:0]  envelope;
		logic [15:0] version_major;
		logic [15:0] version_minor;
		logic [31:0] sequence_id;
	} item_t;

	typedef struct packed {
		logic [2:0]        send_kind;
		logic [31:0]       send_sequence;
		logic [31:0]       acked_sequence;
		logic              write_valid;
		logic [OFF_W-1:0]  write_offset;
		logic [FRAG_W-1:0] write_length;
		logic              message_done;
		logic [ASM_W-1:0]  message_length;
		logic              link_reset;
		logic [2:0]        link_state;
	} result_t;

	typedef struct packed {
		hs_state_t        hs;
		logic [31:0]      tx_seq;
		logic [ASM_W-1:0] asm_len;
	} link_t;

	typedef struct packed {
		logic [15:0] expected_major;
		logic [15:0] expected_minor;
	} cfg_t;

endpackage

`default_nettype wire

@@ hdl/ldc_lhr_cfg.sv @@
// ----------------------------------------------------------------------------
// ldc_lhr_cfg
// expected version registers behind the plain write port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ldc_lhr_cfg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_addr,
	input  wire logic [15:0]        cfg_wdata,
	output ldc_lhr_pkg::cfg_t       cfg
);
	import ldc_lhr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_major <= 16'd1;
			cfg_q.expected_minor <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_MAJOR: cfg_q.expected_major <= cfg_wdata;
				CFG_MINOR: cfg_q.expected_minor <= cfg_wdata;
				default:   cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ hdl/ldc_lhr_step.sv @@
// ----------------------------------------------------------------------------
// ldc_lhr_step
// next link state and result for one registered item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ldc_lhr_step (
	input  wire ldc_lhr_pkg::item_t item,
	input  wire ldc_lhr_pkg::link_t cur,
	input  wire ldc_lhr_pkg::cfg_t  cfg,
	output ldc_lhr_pkg::link_t      nxt,
	output ldc_lhr_pkg::result_t    res
);
	import ldc_lhr_pkg::*;

	logic              down;
	logic              numbered;
	logic              vers_match;
	logic [FRAG_W-1:0] len;
	logic [SUM_W-1:0]  sum;

	assign len        = item.envelope[FRAG_W-1:0];
	assign sum        = {1'b0, cur.asm_len} + SUM_W'(len);
	assign vers_match = (item.version_major == cfg.expected_major) &&
	                    (item.version_minor == cfg.expected_minor);

	always_comb begin
		nxt      = cur;
		res      = '0;
		down     = 1'b0;
		numbered = 1'b0;

		if (item.operation) begin
			res.send_kind = SK_VERS_INFO;
			nxt.hs        = ST_SND_VERS;
		end else if (!item.packet_kind) begin
			unique case (item.ctrl_code)
				CC_VERSION: begin
					if (item.subtype == SUB_INFO) begin
						// mismatch or repeat in received-vers is dropped quietly
						if (cur.hs != ST_RCV_VERS && vers_match) begin
							res.send_kind = SK_VERS_ACK;
							nxt.hs        = ST_RCV_VERS;
						end
					end else if (item.subtype == SUB_ACK) begin
						if (cur.hs != ST_SND_VERS) begin
							down = 1'b1;
						end else begin
							numbered      = 1'b1;
							res.send_kind = SK_RTS;
							nxt.hs        = ST_SND_RTS;
						end
					end else begin
						down = 1'b1;
					end
				end
				CC_RTS: begin
					if (item.subtype != SUB_INFO || cur.hs != ST_RCV_VERS ||
					    item.envelope != MODE_RELIABLE) begin
						down = 1'b1;
					end else begin
						numbered      = 1'b1;
						res.send_kind = SK_RTR;
						nxt.hs        = ST_SND_RTR;
					end
				end
				CC_RTR: begin
					if (item.subtype != SUB_INFO || cur.hs != ST_SND_RTS ||
					    item.envelope != MODE_RELIABLE) begin
						down = 1'b1;
					end else begin
						numbered      = 1'b1;
						res.send_kind = SK_RDX;
						nxt.hs        = ST_SND_RDX;
					end
				end
				CC_RDX: begin
					if (item.subtype != SUB_INFO || cur.hs != ST_SND_RTR) begin
						down = 1'b1;
					end
				end
				default: begin
					down = 1'b1;
				end
			endcase
		end else begin
			if (item.subtype != SUB_INFO && item.subtype != SUB_ACK) begin
				down = 1'b1;
			end else if (cur.hs != ST_SND_RTR && cur.hs != ST_SND_RDX) begin
				down = 1'b1;
			end else if (item.subtype == SUB_INFO) begin
				if (item.envelope[ENV_START_BIT]) begin
					nxt.asm_len = ASM_W'(len);
				end else if (sum > SUM_W'(MSG_BYTES)) begin
					// overrun: drop the fragment and reset the link
					down = 1'b1;
				end else begin
					res.write_offset = cur.asm_len[OFF_W-1:0];
					nxt.asm_len      = sum[ASM_W-1:0];
				end
				if (!down) begin
					if (len != '0) begin
						res.write_valid  = 1'b1;
						res.write_length = len;
					end else begin
						res.write_offset = '0;
					end
					if (item.envelope[ENV_STOP_BIT]) begin
						numbered           = 1'b1;
						res.send_kind      = SK_DATA_ACK;
						res.acked_sequence = item.sequence_id;
						res.message_done   = 1'b1;
						res.message_length = nxt.asm_len;
					end
				end
			end
		end

		if (numbered) begin
			res.send_sequence = cur.tx_seq;
			nxt.tx_seq        = cur.tx_seq + 32'd1;
		end
		if (down) begin
			nxt.hs         = ST_IDLE;
			nxt.tx_seq     = '0;
			res.link_reset = 1'b1;
		end
		res.link_state = nxt.hs;
	end

endmodule

`default_nettype wire

@@ hdl/ldc_link_handshake_reassembly.sv @@
// ----------------------------------------------------------------------------
// ldc_link_handshake_reassembly
// reliable-mode link receiver: handshake and fragment reassembly
// ----------------------------------------------------------------------------
// usage
//   s_* channel: one transfer per start command or received packet header
//   m_* channel: exactly one result transfer per input transfer, in order
//   cfg_*: expected link version, written while the block is idle
// result path
//   the transfer edge loads the input register; the result register loads
//   when stage 1 advances, and m_tvalid then offers the result
// throughput
//   one transfer per cycle unless m_tready stalls; handshake state, transmit
//   sequence and message length update in a single pass of the step logic
// stall
//   while m_tready is low the result register holds and one more input
//   transfer is taken into the input register; s_tready then drops
// reset
//   arst_n clears both stages, the handshake state (idle), the transmit
//   sequence and the assembled length; version registers go to 1.0
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ldc_link_handshake_reassembly_defines.svh"

module ldc_link_handshake_reassembly (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// input stream
	input  wire logic          s_tvalid,
	output logic               s_tready,
	// subtype, ctrl_code, envelope, version_major, version_minor, sequence_id
	input  wire logic [79:0]   s_tdata,
	// operation, packet_kind
	input  wire logic [1:0]    s_tuser,
	// result stream
	output logic               m_tvalid,
	input  wire logic          m_tready,
	// send_sequence, acked_sequence, write_valid, write_offset, write_length,
	// message_done, message_length, link_reset, link_state
	output logic [103:0]       m_tdata,
	// send_kind
	output logic [2:0]         m_tuser,
	// configuration write port
	input  wire logic          cfg_we,
	input  wire logic          cfg_addr,
	input  wire logic [15:0]   cfg_wdata
);
	import ldc_lhr_pkg::*;

	cfg_t    cfg;
	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	link_t   link_q;
	link_t   nxt;
	logic    s_accept;
	logic    adv;
	logic    seq_sent;

	// unpack the input transfer
	assign item_in.operation     = s_tuser[0];
	assign item_in.packet_kind   = s_tuser[1];
	assign item_in.subtype       = s_tdata[1:0];
	assign item_in.ctrl_code     = s_tdata[4:2];
	assign item_in.envelope      = s_tdata[12:5];
	assign item_in.version_major = s_tdata[28:13];
	assign item_in.version_minor = s_tdata[44:29];
	assign item_in.sequence_id   = s_tdata[76:45];

	// stage 1 moves on whenever the result register is free or being drained
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign s_accept = s_tvalid && s_tready;

	ldc_lhr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ldc_lhr_step u_step (
		.item (item_s1),
		.cur  (link_q),
		.cfg  (cfg),
		.nxt  (nxt),
		.res  (res)
	);

	// input register payload
	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1 <= item_in;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	// stage valids and link state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			link_q.hs      <= ST_IDLE;
			link_q.tx_seq  <= '0;
			link_q.asm_len <= '0;
		end else begin
			if (s_accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
				link_q   <= nxt;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// pack the result transfer
	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.send_kind;
	assign m_tdata  = {3'b000,
	                   res_s2.link_state,
	                   res_s2.link_reset,
	                   res_s2.message_length,
	                   res_s2.message_done,
	                   res_s2.write_length,
	                   res_s2.write_offset,
	                   res_s2.write_valid,
	                   res_s2.acked_sequence,
	                   res_s2.send_sequence};

	// packets that carry a transmit sequence number
	assign seq_sent = (res.send_kind == SK_RTS) || (res.send_kind == SK_RTR) ||
	                  (res.send_kind == SK_RDX) || (res.send_kind == SK_DATA_ACK);

	// a forced link reset leaves the link idle with the sequence cleared
	`LDC_LHR_ASSERT_NEXT(a_reset_clears, adv && res.link_reset, link_q.hs == ST_IDLE && link_q.tx_seq == '0)

	// every numbered packet advances the transmit sequence by one
	`LDC_LHR_ASSERT_NEXT(a_seq_step, adv && seq_sent, link_q.tx_seq == $past(link_q.tx_seq) + 32'd1)

	// input side only backs up when both stages are full and the sink stalls
	`LDC_LHR_ASSERT_NOW(a_ready_stall, !s_tready, valid_s1 && valid_s2 && !m_tready)

	// a completed message always carries a data ack
	`LDC_LHR_ASSERT_NOW(a_done_ack, valid_s2 && res_s2.message_done, res_s2.send_kind == SK_DATA_ACK)

endmodule

`default_nettype wire

@@ tb/ldc_lhr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldc link handshake reassembly checker
// predicts the result of every input transfer and compares it with the
// result stream, field by field, in order
// ----------------------------------------------------------------------------
module ldc_lhr_checker
	import ldc_lhr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	// subtype, ctrl_code, envelope, version_major, version_minor, sequence_id
	input  logic [79:0]  s_tdata,
	// operation, packet_kind
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	// send_sequence, acked_sequence, write_valid, write_offset, write_length,
	// message_done, message_length, link_reset, link_state
	input  logic [103:0] m_tdata,
	// send_kind
	input  logic [2:0]   m_tuser,
	input  logic         cfg_we,
	input  logic         cfg_addr,
	input  logic [15:0]  cfg_wdata,
	output int           failures,
	output int           outstanding
);

	localparam int MAX_PRINTS = 40;

	// link state as this side sees it
	hs_state_t        hs;
	logic [31:0]      tx_seq;
	logic [ASM_W-1:0] asm_len;
	cfg_t             cfg;

	result_t          link_results[$];
	int               results_checked;

	initial failures = 0;

	task automatic report(input string msg);
		if (failures < MAX_PRINTS)
			$display("%0t ns mismatch: %s", $time, msg);
		failures++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got_v,
			input logic [31:0] want_v);
		if (got_v !== want_v)
			report($sformatf("result %0d %s got %0h expected %0h",
				results_checked, name, got_v, want_v));
	endtask

	function automatic void link_down(inout result_t r);
		hs = ST_IDLE;
		tx_seq = '0;
		r.link_reset = 1'b1;
	endfunction

	function automatic void send_numbered(inout result_t r, input logic [2:0] kind,
			input hs_state_t nxt);
		r.send_kind = kind;
		r.send_sequence = tx_seq;
		tx_seq = tx_seq + 32'd1;
		hs = nxt;
	endfunction

	function automatic result_t link_step(input item_t it);
		result_t          r;
		logic [5:0]       frag_len;
		logic [ASM_W:0]   sum;
		logic [ASM_W-1:0] start_off;
		r = '0;
		start_off = '0;
		if (it.operation) begin
			r.send_kind = SK_VERS_INFO;
			hs = ST_SND_VERS;
		end else if (!it.packet_kind) begin
			case (it.ctrl_code)
				CC_VERSION: begin
					if (it.subtype == SUB_INFO) begin
						// mismatch and repeat in received-vers are silent
						if (hs != ST_RCV_VERS && it.version_major == cfg.expected_major &&
								it.version_minor == cfg.expected_minor) begin
							r.send_kind = SK_VERS_ACK;
							hs = ST_RCV_VERS;
						end
					end else if (it.subtype == SUB_ACK) begin
						if (hs == ST_SND_VERS)
							send_numbered(r, SK_RTS, ST_SND_RTS);
						else
							link_down(r);
					end else begin
						link_down(r);
					end
				end
				CC_RTS: begin
					if (it.subtype == SUB_INFO && hs == ST_RCV_VERS &&
							it.envelope == MODE_RELIABLE)
						send_numbered(r, SK_RTR, ST_SND_RTR);
					else
						link_down(r);
				end
				CC_RTR: begin
					if (it.subtype == SUB_INFO && hs == ST_SND_RTS &&
							it.envelope == MODE_RELIABLE)
						send_numbered(r, SK_RDX, ST_SND_RDX);
					else
						link_down(r);
				end
				CC_RDX: begin
					if (it.subtype != SUB_INFO || hs != ST_SND_RTR)
						link_down(r);
				end
				default: begin
					link_down(r);
				end
			endcase
		end else if (it.subtype != SUB_INFO && it.subtype != SUB_ACK) begin
			link_down(r);
		end else if (hs != ST_SND_RTR && hs != ST_SND_RDX) begin
			link_down(r);
		end else if (it.subtype == SUB_INFO) begin
			frag_len = it.envelope[5:0];
			sum = {1'b0, asm_len} + frag_len;
			if (it.envelope[ENV_START_BIT]) begin
				asm_len = frag_len;
			end else if (sum > MSG_BYTES) begin
				link_down(r);
			end else begin
				start_off = asm_len;
				asm_len = sum[ASM_W-1:0];
			end
			if (!r.link_reset) begin
				if (frag_len != 6'd0) begin
					r.write_valid = 1'b1;
					r.write_length = frag_len;
					r.write_offset = start_off[OFF_W-1:0];
				end
				if (it.envelope[ENV_STOP_BIT]) begin
					send_numbered(r, SK_DATA_ACK, hs);
					r.acked_sequence = it.sequence_id;
					r.message_done = 1'b1;
					r.message_length = asm_len;
				end
			end
		end
		r.link_state = hs;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		item_t   it;
		result_t got;
		result_t want;
		if (!arst_n) begin
			hs = ST_IDLE;
			tx_seq = '0;
			asm_len = '0;
			cfg.expected_major = 16'd1;
			cfg.expected_minor = 16'd0;
			link_results.delete();
			results_checked = 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.send_kind      = m_tuser;
				got.send_sequence  = m_tdata[31:0];
				got.acked_sequence = m_tdata[63:32];
				got.write_valid    = m_tdata[64];
				got.write_offset   = m_tdata[76:65];
				got.write_length   = m_tdata[82:77];
				got.message_done   = m_tdata[83];
				got.message_length = m_tdata[96:84];
				got.link_reset     = m_tdata[97];
				got.link_state     = m_tdata[100:98];
				if (link_results.size() == 0) begin
					report("result transfer with no input transfer pending");
				end else begin
					want = link_results.pop_front();
					check_field("send_kind", got.send_kind, want.send_kind);
					check_field("send_sequence", got.send_sequence, want.send_sequence);
					check_field("acked_sequence", got.acked_sequence, want.acked_sequence);
					check_field("write_valid", got.write_valid, want.write_valid);
					check_field("write_offset", got.write_offset, want.write_offset);
					check_field("write_length", got.write_length, want.write_length);
					check_field("message_done", got.message_done, want.message_done);
					check_field("message_length", got.message_length, want.message_length);
					check_field("link_reset", got.link_reset, want.link_reset);
					check_field("link_state", got.link_state, want.link_state);
				end
				results_checked++;
			end
			if (s_tvalid && s_tready) begin
				it.operation     = s_tuser[0];
				it.packet_kind   = s_tuser[1];
				it.subtype       = s_tdata[1:0];
				it.ctrl_code     = s_tdata[4:2];
				it.envelope      = s_tdata[12:5];
				it.version_major = s_tdata[28:13];
				it.version_minor = s_tdata[44:29];
				it.sequence_id   = s_tdata[76:45];
				link_results.push_back(link_step(it));
			end
			if (cfg_we) begin
				if (cfg_addr == CFG_MAJOR)
					cfg.expected_major = cfg_wdata;
				else
					cfg.expected_minor = cfg_wdata;
			end
			outstanding <= link_results.size();
		end
	end

endmodule

@@ tb/tb_ldc_link_handshake_reassembly.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldc link handshake reassembly testbench
// drives start commands and packet headers through handshakes, message
// reassembly and broken sequences under random stalls on both streams,
// across several version settings; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_ldc_link_handshake_reassembly;
	import ldc_lhr_pkg::*;

	localparam int CLK_PERIOD    = 12;
	localparam int RESET_CYCLES  = 7;
	localparam int ITEM_TARGET   = 1100;
	localparam int PHASES        = 4;
	localparam int HOLD_CYCLES   = 150;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT   = 500000;
	// full fragments ahead of the tail of a long message: 65 * 63 = 4095 bytes
	localparam int FULL_FRAGS    = 65;

	// item codes not named by the package
	localparam logic       OP_PACKET = 1'b0;
	localparam logic       OP_START  = 1'b1;
	localparam logic       KIND_CTRL = 1'b0;
	localparam logic       KIND_DATA = 1'b1;
	localparam logic [1:0] SUB_NACK  = 2'd2;
	localparam logic [1:0] SUB_OTHER = 2'd3;
	localparam logic [2:0] CC_UNUSED = 3'd7;

	// message shapes
	localparam int SHAPE_RANDOM  = 0;
	localparam int SHAPE_FILL    = 1;
	localparam int SHAPE_OVERRUN = 2;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [79:0]   s_tdata;
	logic [1:0]    s_tuser;
	logic          m_tvalid;
	logic          m_tready;
	logic [103:0]  m_tdata;
	logic [2:0]    m_tuser;
	logic          cfg_we;
	logic          cfg_addr;
	logic [15:0]   cfg_wdata;

	int            failures;
	int            outstanding;
	int unsigned   cycle_count;
	int            items_sent;
	int            sender_style;
	int            hold_requests = 0;
	int            holds_served = 0;
	// version the block currently accepts
	logic [15:0]   link_major;
	logic [15:0]   link_minor;

	always #(CLK_PERIOD / 2) clk = ~clk;

	ldc_link_handshake_reassembly dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	ldc_lhr_checker link_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.failures    (failures),
		.outstanding (outstanding)
	);

	// item builders: fields that the packet does not use stay random
	function automatic item_t random_item();
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		return raw[$bits(item_t)-1:0];
	endfunction

	function automatic item_t start_cmd();
		item_t it;
		it = random_item();
		it.operation = OP_START;
		return it;
	endfunction

	function automatic item_t ctrl_pkt(input logic [1:0] sub, input logic [2:0] code,
			input logic [7:0] env);
		item_t it;
		it = random_item();
		it.operation = OP_PACKET;
		it.packet_kind = KIND_CTRL;
		it.subtype = sub;
		it.ctrl_code = code;
		it.envelope = env;
		return it;
	endfunction

	function automatic item_t version_pkt(input logic [15:0] major, input logic [15:0] minor);
		item_t it;
		it = ctrl_pkt(SUB_INFO, CC_VERSION, 8'($urandom));
		it.version_major = major;
		it.version_minor = minor;
		return it;
	endfunction

	function automatic item_t data_pkt(input logic [1:0] sub, input logic [7:0] env);
		item_t it;
		it = random_item();
		it.operation = OP_PACKET;
		it.packet_kind = KIND_DATA;
		it.subtype = sub;
		it.envelope = env;
		return it;
	endfunction

	// fragment envelope: stop flag, start flag, payload length
	function automatic logic [7:0] frag_env(input logic first, input logic last,
			input logic [5:0] len);
		return {last, first, len};
	endfunction

	// idle cycles after a transfer; style 0 keeps the input stream saturated
	function automatic int sender_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (sender_style == 0 || roll < 70)
			return 0;
		if (roll < 96)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_item(input item_t it);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, it.sequence_id, it.version_minor, it.version_major,
			it.envelope, it.ctrl_code, it.subtype};
		s_tuser  <= {it.packet_kind, it.operation};
		do @(posedge clk); while (s_tready !== 1'b1);
		items_sent++;
		gap = sender_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// handshake step that now and then turns into a random packet
	task automatic send_step(input item_t it);
		if ($urandom_range(0, 24) == 0)
			send_item(random_item());
		else
			send_item(it);
	endtask

	// sender stops and waits until every result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_config(input logic [15:0] major, input logic [15:0] minor);
		cfg_we    <= 1'b1;
		cfg_addr  <= CFG_MAJOR;
		cfg_wdata <= major;
		@(posedge clk);
		cfg_addr  <= CFG_MINOR;
		cfg_wdata <= minor;
		@(posedge clk);
		cfg_we    <= 1'b0;
		link_major = major;
		link_minor = minor;
	endtask

	task automatic send_message(input int shape);
		int         n_frags;
		int         f;
		logic [5:0] len;
		logic       first;
		logic       last;
		n_frags = (shape == SHAPE_RANDOM) ? $urandom_range(1, 6) : FULL_FRAGS + 1;
		for (f = 0; f < n_frags; f++) begin
			first = (f == 0);
			last = (f == n_frags - 1);
			if (shape == SHAPE_RANDOM) begin
				len = ($urandom_range(0, 7) == 0) ? 6'd0 : 6'($urandom);
				// stray start or stop flags restart or cut the message
				if ($urandom_range(0, 11) == 0)
					first = ~first;
				if ($urandom_range(0, 11) == 0)
					last = ~last;
			end else if (last) begin
				// tail lands exactly on the buffer end, or one byte past it
				len = (shape == SHAPE_FILL) ? 6'd1 : 6'd2;
			end else begin
				len = 6'd63;
			end
			// peer data acks in a ready state change nothing
			if ($urandom_range(0, 9) == 0)
				send_item(data_pkt(SUB_ACK, 8'($urandom)));
			send_item(data_pkt(SUB_INFO, frag_env(first, last, len)));
		end
	endtask

	// one link bring-up from either side, then messages, sometimes noise
	task automatic run_session(input int shape);
		if ($urandom_range(0, 1) == 0) begin
			// local side opens: version info out, peer acks, rts out, peer rtr
			send_step(start_cmd());
			if ($urandom_range(0, 5) == 0)
				send_step(start_cmd());
			send_step(ctrl_pkt(SUB_ACK, CC_VERSION, 8'($urandom)));
			send_step(ctrl_pkt(SUB_INFO, CC_RTR, MODE_RELIABLE));
		end else begin
			// peer opens: its version info, its rts, optionally its rdx
			if ($urandom_range(0, 5) == 0)
				send_step(version_pkt(link_major ^ 16'($urandom_range(1, 65535)),
					link_minor));
			send_step(version_pkt(link_major, link_minor));
			send_step(ctrl_pkt(SUB_INFO, CC_RTS, MODE_RELIABLE));
			if ($urandom_range(0, 1) == 0)
				send_step(ctrl_pkt(SUB_INFO, CC_RDX, 8'($urandom)));
		end
		if (shape != SHAPE_RANDOM)
			send_message(shape);
		else
			repeat ($urandom_range(1, 5)) send_message(SHAPE_RANDOM);
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 3)) send_item(random_item());
	endtask

	// result side: stretches of steady ready, short stalls and long stalls,
	// plus a long hold-off whenever the stimulus asks for one
	initial begin : result_sink
		int stall_left;
		int seg_left;
		int style;
		int roll;
		stall_left = 0;
		seg_left = 0;
		style = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_requests != holds_served) begin
				// input side keeps offering transfers, so the block backs up
				holds_served++;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(20, 120);
					style = $urandom_range(0, 2);
				end
				seg_left--;
				roll = $urandom_range(0, 99);
				if (stall_left > 0) begin
					stall_left--;
					m_tready <= 1'b0;
				end else if (style == 0) begin
					m_tready <= 1'b1;
				end else if (roll < 4) begin
					stall_left = $urandom_range(8, 40);
					m_tready <= 1'b0;
				end else if (roll < (style == 1 ? 15 : 45)) begin
					stall_left = $urandom_range(0, 2);
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
				@(posedge clk);
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ldc_link_handshake_reassembly regression: fail");
		$finish;
	end

	initial begin : stimulus
		item_t       it;
		int          phase;
		int          sessions;
		int          phase_end;
		logic [15:0] major;
		logic [15:0] minor;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		cfg_we    <= 1'b0;
		cfg_addr  <= CFG_MAJOR;
		cfg_wdata <= '0;
		items_sent = 0;
		sender_style = 1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_config(16'd1, 16'd0);

		// directed: peer-opened handshake and a short message
		send_item(version_pkt(link_major, link_minor));             // vers ack
		send_item(version_pkt(link_major, link_minor));             // repeat ignored
		send_item(ctrl_pkt(SUB_INFO, CC_RTS, MODE_RELIABLE));       // rtr, seq 0
		send_item(ctrl_pkt(SUB_INFO, CC_RDX, 8'hff));               // silently taken
		send_item(data_pkt(SUB_INFO, frag_env(1'b1, 1'b0, 6'd63))); // offset 0
		send_item(data_pkt(SUB_INFO, frag_env(1'b0, 1'b0, 6'd0)));  // empty fragment
		send_item(data_pkt(SUB_ACK, 8'hff));                        // no effect
		it = data_pkt(SUB_INFO, frag_env(1'b0, 1'b1, 6'd1));
		it.sequence_id = '1;
		send_item(it);                                              // data ack, 64 bytes
		send_item(version_pkt(~link_major, link_minor));            // major mismatch
		send_item(version_pkt(link_major, ~link_minor));            // minor mismatch
		send_item(ctrl_pkt(SUB_ACK, CC_VERSION, 8'h00));            // ack out of turn
		send_item(start_cmd());
		send_item(ctrl_pkt(SUB_NACK, CC_VERSION, 8'h00));           // nack resets
		// directed: locally opened handshake
		send_item(start_cmd());
		send_item(ctrl_pkt(SUB_ACK, CC_VERSION, 8'h55));            // rts, seq 0
		send_item(ctrl_pkt(SUB_INFO, CC_RTR, MODE_RELIABLE));       // rdx, seq 1
		send_item(data_pkt(SUB_INFO, frag_env(1'b1, 1'b1, 6'd0)));  // empty message
		send_item(data_pkt(SUB_OTHER, 8'h00));                      // bad data subtype
		send_item(data_pkt(SUB_INFO, frag_env(1'b1, 1'b0, 6'd5)));  // data while idle
		send_item(ctrl_pkt(SUB_INFO, CC_UNUSED, MODE_RELIABLE));    // unknown code
		send_item(version_pkt(link_major, link_minor));
		send_item(ctrl_pkt(SUB_INFO, CC_RTS, 8'h02));               // wrong mode
		send_item(version_pkt(link_major, link_minor));
		send_item(ctrl_pkt(SUB_OTHER, CC_RTS, MODE_RELIABLE));      // unknown subtype

		// random phases, each under its own version setting
		for (phase = 0; phase < PHASES; phase++) begin
			drain_results();
			repeat (SETTLE_CYCLES) @(posedge clk);
			case (phase)
				0: begin
					major = 16'h0000;
					minor = 16'h0000;
				end
				1: begin
					major = 16'hffff;
					minor = 16'hffff;
				end
				2: begin
					major = 16'($urandom);
					minor = 16'($urandom);
				end
				default: begin
					major = 16'h0001;
					minor = 16'h0000;
				end
			endcase
			write_config(major, minor);
			phase_end = items_sent + ITEM_TARGET / PHASES;
			if (phase == 1) begin
				// saturated input against a stalled result side
				sender_style = 0;
				hold_requests <= hold_requests + 1;
			end else begin
				sender_style = $urandom_range(0, 2);
			end
			sessions = 0;
			while (items_sent < phase_end) begin
				if (sessions > 0 && sessions % 6 == 0)
					sender_style = $urandom_range(0, 2);
				// one long message per phase: exact fill or overrun
				if (sessions == 2)
					run_session(phase % 2 == 0 ? SHAPE_FILL : SHAPE_OVERRUN);
				else
					run_session(SHAPE_RANDOM);
				sessions++;
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES * 4) @(posedge clk);
		if (failures == 0)
			$display("ldc_link_handshake_reassembly regression: pass");
		else
			$display("ldc_link_handshake_reassembly regression: fail");
		$finish;
	end

endmodule
